// File: hdl/tnsilf_pkg.sv
// Shared types, constants and helper functions of the TNS inverse lattice filter.
// Holds the microcode table, the reflection coefficient table and the saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package tnsilf_pkg;

  localparam int LATTICE_STAGES_DEF = 8;
  localparam int SAMPLE_BITS_DEF    = 24;

  localparam int ACC_W   = 32;            // lattice accumulator and state width
  localparam int SUM_W   = ACC_W + 2;     // headroom before saturation
  localparam int COEF_W  = 16;            // Q1.15 coefficient
  localparam int FRAC    = 15;
  localparam int PROD_W  = ACC_W + COEF_W;
  localparam int RND_W   = PROD_W - FRAC;
  localparam int IDX_W   = 5;             // packed reflection index
  localparam int PACK_W  = 40;
  localparam int POS_W   = 9;
  localparam int START_W = 6;
  localparam int BAND_W  = 9;
  localparam int NF_W    = 2;
  localparam int ORD_W   = 4;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;
  localparam int REG_W   = 3;             // register index within the address

  localparam int COEF_MAX_IDX = 8;
  localparam int TAB_W        = 4;

  // register indexes
  localparam logic [REG_W-1:0] REG_START         = 3'd0;
  localparam logic [REG_W-1:0] REG_BAND_LENGTH   = 3'd1;
  localparam logic [REG_W-1:0] REG_NUM_FILTERS   = 3'd2;
  localparam logic [REG_W-1:0] REG_ORDER_FIRST   = 3'd3;
  localparam logic [REG_W-1:0] REG_ORDER_SECOND  = 3'd4;
  localparam logic [REG_W-1:0] REG_COEFFS_FIRST  = 3'd5;
  localparam logic [REG_W-1:0] REG_COEFFS_SECOND = 3'd6;

  localparam logic [START_W-1:0] START_RST = 6'd18;
  localparam logic [BAND_W-1:0]  BAND_RST  = 9'd400;
  localparam logic [NF_W-1:0]    NF_RST    = 2'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2**(FRAC-1));

  // sin(i*pi/17) in Q1.15
  localparam logic signed [COEF_W-1:0] COEF_TAB [COEF_MAX_IDX+1] = '{
    16'sd0, 16'sd6021, 16'sd11837, 16'sd17250, 16'sd22076,
    16'sd26149, 16'sd29333, 16'sd31517, 16'sd32628
  };

  // microcode steps
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_LOAD  = 3'd1;
  localparam step_t STEP_FIRST = 3'd2;
  localparam step_t STEP_SUB   = 3'd3;
  localparam step_t STEP_MUL   = 3'd4;
  localparam step_t STEP_FIN   = 3'd5;
  localparam step_t STEP_BYP   = 3'd6;

  typedef enum logic [2:0] {
    JC_NEXT,        // fall through
    JC_GOTO,        // always jump
    JC_WAIT_REQ,    // hold until a request arrives, then fall through
    JC_IF_BYPASS,   // jump when the item is not filtered
    JC_LOOP,        // jump while stages remain
    JC_WAIT_OUT     // hold until the output register is free, then jump
  } jcond_t;

  typedef struct packed {
    logic   take;   // accept a request
    logic   ld;     // load accumulator, prefetch top-stage product
    logic   sub;    // acc -= round(ps)
    logic   upd;    // pending state update
    logic   mula;   // pa = acc * c[k]
    logic   muls;   // ps = s[k-1] * c[k-1], step k down
    logic   fin;    // write s[0], band-end clear, emit filtered
    logic   byp;    // emit unchanged sample
    jcond_t jc;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    logic req;
    logic bypass;
    logic more;
    logic out_free;
  } cond_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      STEP_WAIT: begin
        w.take = 1'b1; w.jc = JC_WAIT_REQ; w.target = STEP_WAIT;
      end
      STEP_LOAD: begin
        w.ld = 1'b1; w.jc = JC_IF_BYPASS; w.target = STEP_BYP;
      end
      STEP_FIRST: begin
        w.sub = 1'b1; w.muls = 1'b1; w.jc = JC_NEXT; w.target = STEP_WAIT;
      end
      STEP_SUB: begin
        w.sub = 1'b1; w.upd = 1'b1; w.jc = JC_NEXT; w.target = STEP_WAIT;
      end
      STEP_MUL: begin
        w.mula = 1'b1; w.muls = 1'b1; w.jc = JC_LOOP; w.target = STEP_SUB;
      end
      STEP_FIN: begin
        w.upd = 1'b1; w.fin = 1'b1; w.jc = JC_WAIT_OUT; w.target = STEP_WAIT;
      end
      STEP_BYP: begin
        w.byp = 1'b1; w.jc = JC_WAIT_OUT; w.target = STEP_WAIT;
      end
      default: begin
        w.jc = JC_GOTO; w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_q15(input logic [IDX_W-1:0] f);
    logic [IDX_W-1:0] m;
    logic [TAB_W-1:0] mi;
    m  = f[IDX_W-1] ? IDX_W'(~f + 1'b1) : f;
    // magnitude above the table end saturates, sign kept
    mi = (m > IDX_W'(COEF_MAX_IDX)) ? TAB_W'(COEF_MAX_IDX) : m[TAB_W-1:0];
    return f[IDX_W-1] ? -COEF_TAB[mi] : COEF_TAB[mi];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(ACC_MAX)) return ACC_MAX;
    if (v < SUM_W'(ACC_MIN)) return ACC_MIN;
    return v[ACC_W-1:0];
  endfunction

  // round half up, then floor-shift by the fraction bits
  function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return t[PROD_W-1:FRAC];
  endfunction

endpackage

// File: hdl/tnsilf_seq.sv
// Microcode sequencer of the TNS inverse lattice filter: step counter and jump logic.
// Reads the control table from tnsilf_pkg and drives the datapath control word.
`timescale 1ns / 1ps

module tnsilf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tnsilf_pkg::cond_t   cond,
  output tnsilf_pkg::ucode_t  ctl
);

  tnsilf_pkg::step_t step_r;
  tnsilf_pkg::step_t step_nxt;
  tnsilf_pkg::step_t step_inc;

  assign ctl      = tnsilf_pkg::ucode_rom(step_r);
  assign step_inc = step_r + 1'b1;

  always_comb begin
    case (ctl.jc)
      tnsilf_pkg::JC_NEXT:      step_nxt = step_inc;
      tnsilf_pkg::JC_GOTO:      step_nxt = ctl.target;
      tnsilf_pkg::JC_WAIT_REQ:  step_nxt = cond.req ? step_inc : step_r;
      tnsilf_pkg::JC_IF_BYPASS: step_nxt = cond.bypass ? ctl.target : step_inc;
      tnsilf_pkg::JC_LOOP:      step_nxt = cond.more ? ctl.target : step_inc;
      tnsilf_pkg::JC_WAIT_OUT:  step_nxt = cond.out_free ? ctl.target : step_r;
      default:                  step_nxt = tnsilf_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tnsilf_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: hdl/tns_inverse_lattice_filter_unit.sv
// Filtered bins run through the load step, the first subtract, the subtract and multiply loop over
// the lattice stages and the finish step; pass-through bins go from the load step to the bypass step.
// The single shared multiply-and-accumulate lattice loop handles one request at a time.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, synchronous): registers to defaults, lattice state and bin count to zero.
// Depends on tnsilf_pkg and tnsilf_seq.
`timescale 1ns / 1ps

module tns_inverse_lattice_filter_unit #(
  parameter int LATTICE_STAGES = tnsilf_pkg::LATTICE_STAGES_DEF,
  parameter int SAMPLE_BITS    = tnsilf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_filtered,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tnsilf_pkg::CFG_AW-1:0]       paddr,
  input  logic [tnsilf_pkg::CFG_DW-1:0]       pwdata,
  output logic [tnsilf_pkg::CFG_DW-1:0]       prdata,
  output logic                                pready
);

  localparam int CW    = $clog2(LATTICE_STAGES);
  localparam int ACC_W = tnsilf_pkg::ACC_W;
  localparam int SUM_W = tnsilf_pkg::SUM_W;
  localparam int ORD_W = tnsilf_pkg::ORD_W;
  localparam int POS_W = tnsilf_pkg::POS_W;
  localparam int BAND_W = tnsilf_pkg::BAND_W;
  localparam int PROD_W = tnsilf_pkg::PROD_W;
  localparam int COEF_W = tnsilf_pkg::COEF_W;
  localparam int IDX_W  = tnsilf_pkg::IDX_W;
  localparam int PACK_W = tnsilf_pkg::PACK_W;
  localparam logic [CW-1:0]    K_TOP   = CW'(LATTICE_STAGES - 1);
  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(LATTICE_STAGES);
  localparam logic [POS_W-1:0] POS_LAST = {POS_W{1'b1}};
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // ---------------- configuration registers ----------------
  logic [tnsilf_pkg::START_W-1:0] start_r;
  logic [BAND_W-1:0]              band_r;
  logic [tnsilf_pkg::NF_W-1:0]    nf_r;
  logic [ORD_W-1:0]               ord0_r, ord1_r;
  logic [PACK_W-1:0]              c0_r, c1_r;
  logic                           cfg_wr;
  logic [tnsilf_pkg::REG_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[tnsilf_pkg::CFG_AW-1:tnsilf_pkg::CFG_AW-tnsilf_pkg::REG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= tnsilf_pkg::START_RST;
      band_r  <= tnsilf_pkg::BAND_RST;
      nf_r    <= tnsilf_pkg::NF_RST;
      ord0_r  <= '0;
      ord1_r  <= '0;
      c0_r    <= '0;
      c1_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tnsilf_pkg::REG_START:         start_r <= pwdata[tnsilf_pkg::START_W-1:0];
        tnsilf_pkg::REG_BAND_LENGTH:   band_r  <= pwdata[BAND_W-1:0];
        tnsilf_pkg::REG_NUM_FILTERS:   nf_r    <= pwdata[tnsilf_pkg::NF_W-1:0];
        tnsilf_pkg::REG_ORDER_FIRST:   ord0_r  <= pwdata[ORD_W-1:0];
        tnsilf_pkg::REG_ORDER_SECOND:  ord1_r  <= pwdata[ORD_W-1:0];
        tnsilf_pkg::REG_COEFFS_FIRST:  c0_r    <= pwdata[PACK_W-1:0];
        tnsilf_pkg::REG_COEFFS_SECOND: c1_r    <= pwdata[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tnsilf_pkg::REG_START:         prdata = tnsilf_pkg::CFG_DW'(start_r);
      tnsilf_pkg::REG_BAND_LENGTH:   prdata = tnsilf_pkg::CFG_DW'(band_r);
      tnsilf_pkg::REG_NUM_FILTERS:   prdata = tnsilf_pkg::CFG_DW'(nf_r);
      tnsilf_pkg::REG_ORDER_FIRST:   prdata = tnsilf_pkg::CFG_DW'(ord0_r);
      tnsilf_pkg::REG_ORDER_SECOND:  prdata = tnsilf_pkg::CFG_DW'(ord1_r);
      tnsilf_pkg::REG_COEFFS_FIRST:  prdata = tnsilf_pkg::CFG_DW'(c0_r);
      tnsilf_pkg::REG_COEFFS_SECOND: prdata = tnsilf_pkg::CFG_DW'(c1_r);
      default:                       prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  tnsilf_pkg::ucode_t ctl;
  tnsilf_pkg::cond_t  cond;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic                          out_free;
  logic                          act_r;
  logic [CW-1:0]                 k_r;

  assign out_free      = ~out_valid_r | out_ready;
  assign cond.req      = in_valid;
  assign cond.bypass   = ~act_r;
  assign cond.more     = (k_r != '0);
  assign cond.out_free = out_free;

  tnsilf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  // ---------------- request intake and band decision ----------------
  logic                          accept;
  logic [POS_W-1:0]              pos_cnt_r;
  logic [POS_W-1:0]              pos_eff;
  logic                          in_b0, in_b1;
  logic [ORD_W-1:0]              ord_raw, ord_clip;
  logic [BAND_W:0]               band_end, pos_inc;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          sel_r, last_r;
  logic [ORD_W-1:0]              ord_r;

  assign in_ready = ctl.take;
  assign accept   = ctl.take & in_valid;
  assign pos_eff  = in_frame_start ? '0 : pos_cnt_r;
  assign in_b0    = (band_r != '0) && (pos_eff >= POS_W'(start_r)) && (pos_eff < band_r);
  // a filter count of 0 acts as 1 and 3 as 2: only the upper bit matters
  assign in_b1    = (band_r != '0) && nf_r[1] && (pos_eff >= band_r) &&
                    ({1'b0, pos_eff} < {band_r, 1'b0});
  assign ord_raw  = in_b0 ? ord0_r : ord1_r;
  assign ord_clip = (ord_raw > ORD_MAX) ? ORD_MAX : ord_raw;
  assign band_end = in_b0 ? {1'b0, band_r} : {band_r, 1'b0};
  assign pos_inc  = {1'b0, pos_eff} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
      act_r     <= 1'b0;
    end else if (accept) begin
      pos_cnt_r <= (pos_eff == POS_LAST) ? POS_LAST : pos_inc[POS_W-1:0];
      act_r     <= (in_b0 | in_b1) && (ord_clip != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_sample;
      sel_r  <= ~in_b0;
      ord_r  <= ord_clip;
      last_r <= (pos_inc == band_end);
    end
  end

  // ---------------- lattice datapath ----------------
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] ps_r, pa_r;
  logic [CW-1:0]            pidx_r;
  logic                     pend_r;
  logic signed [ACC_W-1:0]  state_r   [LATTICE_STAGES];
  logic signed [ACC_W-1:0]  state_nxt [LATTICE_STAGES];

  logic [PACK_W-1:0]        packed_sel;
  logic [CW-1:0]            km1, k_ps;
  logic signed [COEF_W-1:0] c_ps, c_pa;
  logic signed [PROD_W-1:0] ps_mul, pa_mul;
  logic signed [ACC_W-1:0]  sub_val, upd_val, out_sat;
  logic                     upd_fire, fin_fire, byp_fire, emit;

  function automatic logic signed [COEF_W-1:0] stage_coef(
    input logic [CW-1:0]     k,
    input logic [ORD_W-1:0]  ord,
    input logic [PACK_W-1:0] pk
  );
    logic [IDX_W-1:0] f;
    f = pk[IDX_W*k +: IDX_W];
    // stages at or above the order use coefficient zero
    return (ORD_W'(k) < ord) ? tnsilf_pkg::coef_q15(f) : '0;
  endfunction

  assign packed_sel = sel_r ? c1_r : c0_r;
  assign km1        = (k_r == '0) ? '0 : k_r - 1'b1;
  assign k_ps       = ctl.ld ? K_TOP : km1;
  assign c_ps       = stage_coef(k_ps, ord_r, packed_sel);
  assign c_pa       = stage_coef(k_r, ord_r, packed_sel);
  assign ps_mul     = PROD_W'(state_r[k_ps]) * PROD_W'(c_ps);
  assign pa_mul     = PROD_W'(acc_r) * PROD_W'(c_pa);

  assign sub_val  = tnsilf_pkg::sat_acc(SUM_W'(acc_r) - SUM_W'(tnsilf_pkg::rnd_q15(ps_r)));
  assign upd_val  = tnsilf_pkg::sat_acc(SUM_W'(state_r[pidx_r]) +
                                        SUM_W'(tnsilf_pkg::rnd_q15(pa_r)));
  assign fin_fire = ctl.fin & out_free;
  assign byp_fire = ctl.byp & out_free;
  assign emit     = fin_fire | byp_fire;
  assign upd_fire = ctl.upd & pend_r & (~ctl.fin | out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (ctl.ld) begin
      pend_r <= 1'b0;
    end else if (ctl.mula) begin
      pend_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      acc_r <= ACC_W'(x_r);
    end else if (ctl.sub) begin
      acc_r <= sub_val;
    end
    if (ctl.ld | ctl.muls) begin
      ps_r <= ps_mul;
    end
    if (ctl.mula) begin
      pa_r   <= pa_mul;
      pidx_r <= k_r;
    end
    if (ctl.ld) begin
      k_r <= K_TOP;
    end else if (ctl.muls) begin
      k_r <= km1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    // frame start clears the whole lattice
    if (accept && in_frame_start) begin
      for (int j = 0; j < LATTICE_STAGES; j++) begin
        state_nxt[j] = '0;
      end
    end
    if (upd_fire) begin
      state_nxt[CW'(pidx_r + 1'b1)] = upd_val;
    end
    if (fin_fire) begin
      state_nxt[0] = acc_r;
      // band end: drop entries at or above this filter's order
      if (last_r) begin
        for (int j = 0; j < LATTICE_STAGES; j++) begin
          if (ORD_W'(j) >= ord_r) begin
            state_nxt[j] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LATTICE_STAGES; j++) begin
        state_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    if (acc_r > OUT_MAX) begin
      out_sat = OUT_MAX;
    end else if (acc_r < OUT_MIN) begin
      out_sat = OUT_MIN;
    end else begin
      out_sat = acc_r;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= byp_fire ? x_r : out_sat[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_r;

endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for tns_inverse_lattice_filter_unit: APB register setup, random traffic.
// A bit-exact lattice predictor in a small class checks each result in order, filtered or passed through.
// Depends on tnsilf_pkg and the filter RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int SW        = tnsilf_pkg::SAMPLE_BITS_DEF;
  localparam int STAGES    = 8;
  localparam int CYCLE_CAP = 400000;
  localparam int SETTLE    = 2 * STAGES + 4;

  class lattice_predictor;
    logic [5:0]  start_idx;
    logic [8:0]  band_len;
    logic [1:0]  nf_raw;
    logic [3:0]  ord0, ord1;
    logic [39:0] cf0, cf1;
    longint      lat[STAGES];
    int unsigned bin_pos;
    logic signed [SW-1:0] expected_bins[$];
    int mismatches;
    int compared;

    function new();
      start_idx = 6'd18; band_len = 9'd400; nf_raw = 2'd1;
      ord0 = 0; ord1 = 0; cf0 = 0; cf1 = 0;
      for (int k = 0; k < STAGES; k++) lat[k] = 0;
      bin_pos = 0;
      mismatches = 0;
      compared = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        tnsilf_pkg::REG_START:         start_idx = v[5:0];
        tnsilf_pkg::REG_BAND_LENGTH:   band_len = v[8:0];
        tnsilf_pkg::REG_NUM_FILTERS:   nf_raw = v[1:0];
        tnsilf_pkg::REG_ORDER_FIRST:   ord0 = v[3:0];
        tnsilf_pkg::REG_ORDER_SECOND:  ord1 = v[3:0];
        tnsilf_pkg::REG_COEFFS_FIRST:  cf0 = v[39:0];
        tnsilf_pkg::REG_COEFFS_SECOND: cf1 = v[39:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // round half up, floor shift
    function longint q15(longint a, longint c);
      return (a * c + 16384) >>> 15;
    endfunction

    function longint sine_q15(int m);
      case (m)
        1: return 6021;
        2: return 11837;
        3: return 17250;
        4: return 22076;
        5: return 26149;
        6: return 29333;
        7: return 31517;
        8: return 32628;
        default: return 0;
      endcase
    endfunction

    function longint refl_coef(logic [39:0] packed_idx, int k);
      logic [4:0] f;
      int idx, mag;
      f = packed_idx[5*k +: 5];
      idx = f[4] ? int'(f) - 32 : int'(f);
      mag = (idx < 0) ? -idx : idx;
      if (mag > 8) mag = 8;
      return (idx < 0) ? -sine_q15(mag) : sine_q15(mag);
    endfunction

    function void note_request(logic signed [SW-1:0] s, logic fs);
      longint x, acc, y;
      longint c[STAGES];
      int nf, band_sel, order;
      int unsigned pos, bl, band_end;
      logic [39:0] pk;
      x = s;
      y = x;
      nf = (nf_raw == 0) ? 1 : ((nf_raw > 2) ? 2 : int'(nf_raw));
      bl = band_len;
      band_sel = -1;
      order = 0;
      band_end = 0;
      pk = 0;
      if (fs) begin
        for (int k = 0; k < STAGES; k++) lat[k] = 0;
        bin_pos = 0;
      end
      pos = bin_pos;
      if (bl != 0) begin
        if (pos >= start_idx && pos < bl) begin
          band_sel = 0; order = ord0; pk = cf0; band_end = bl;
        end else if (nf == 2 && pos >= bl && pos < 2 * bl) begin
          band_sel = 1; order = ord1; pk = cf1; band_end = 2 * bl;
        end
      end
      if (order > STAGES) order = STAGES;
      if (band_sel >= 0 && order != 0) begin
        for (int k = 0; k < STAGES; k++) c[k] = (k < order) ? refl_coef(pk, k) : 0;
        acc = sat(x - q15(lat[STAGES-1], c[STAGES-1]), 32);
        for (int k = STAGES - 2; k >= 0; k--) begin
          acc = sat(acc - q15(lat[k], c[k]), 32);
          lat[k+1] = sat(lat[k] + q15(acc, c[k]), 32);
        end
        lat[0] = acc;
        y = sat(acc, SW);
        // band end: drop the stages at or above this filter's order
        if (pos + 1 == band_end) begin
          for (int j = order; j < STAGES; j++) lat[j] = 0;
        end
      end
      if (bin_pos < 511) bin_pos++;
      expected_bins.push_back(y[SW-1:0]);
    endfunction

    function void check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      compared++;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result %0d with no request pending", got);
        return;
      end
      want = expected_bins.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: filtered expected %0d, got %0d",
                   compared, want, got);
      end
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SW-1:0] in_sample;
  logic in_frame_start;
  logic out_valid;
  logic out_ready;
  logic signed [SW-1:0] out_filtered;
  logic psel, penable, pwrite;
  logic [tnsilf_pkg::CFG_AW-1:0] paddr;
  logic [tnsilf_pkg::CFG_DW-1:0] pwdata;
  logic [tnsilf_pkg::CFG_DW-1:0] prdata;
  logic pready;

  lattice_predictor predictor = new();
  int in_idle_pct;
  int out_idle_pct;
  int cycles;
  int requests_sent;
  int settings_used;

  tns_inverse_lattice_filter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filtered   (out_filtered),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, predictor.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) predictor.check_result(out_filtered);
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic push_request(logic signed [SW-1:0] s, logic fs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    predictor.note_request(s, fs);
    requests_sent++;
  endtask

  // hold off until every request has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    predictor.set_reg(idx, val);
  endtask

  task automatic apply_config(logic [5:0] st, logic [8:0] bl, logic [1:0] nf,
                              logic [3:0] o0, logic [3:0] o1,
                              logic [39:0] c0, logic [39:0] c1);
    cfg_write(tnsilf_pkg::REG_START, 64'(st));
    cfg_write(tnsilf_pkg::REG_BAND_LENGTH, 64'(bl));
    cfg_write(tnsilf_pkg::REG_NUM_FILTERS, 64'(nf));
    cfg_write(tnsilf_pkg::REG_ORDER_FIRST, 64'(o0));
    cfg_write(tnsilf_pkg::REG_ORDER_SECOND, 64'(o1));
    cfg_write(tnsilf_pkg::REG_COEFFS_FIRST, 64'(c0));
    cfg_write(tnsilf_pkg::REG_COEFFS_SECOND, 64'(c1));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return SW'($signed(r[7:0]));
      default: return r[SW-1:0];
    endcase
  endfunction

  function automatic logic [39:0] rand_coeffs();
    logic [39:0] p;
    int v;
    for (int k = 0; k < STAGES; k++) begin
      v = ($urandom_range(7) == 0) ? int'($urandom_range(0, 31)) : int'($urandom_range(0, 16)) - 8;
      p[5*k +: 5] = v[4:0];
    end
    return p;
  endfunction

  // mostly whole frames; now and then a frame carries on without its start marker
  task automatic run_frames(int n_items, int max_len);
    int sent, len;
    logic fs;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len && sent < n_items; i++) begin
        fs = (i == 0) && ($urandom_range(9) != 0);
        push_request(rand_sample(), fs);
        sent++;
      end
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin in_idle_pct = 31; out_idle_pct = 78; end
      1: begin in_idle_pct = 78; out_idle_pct = 31; end
      default: begin in_idle_pct = 0; out_idle_pct = 0; end
    endcase
  endtask

  task automatic random_phase(int ph);
    logic [5:0] st;
    logic [8:0] bl;
    logic [1:0] nf;
    logic [3:0] o0, o1;
    bl = ($urandom_range(7) == 0) ? 9'd0 : 9'($urandom_range(1, 24));
    st = ($urandom_range(5) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, bl));
    nf = 2'($urandom_range(0, 3));
    o0 = ($urandom_range(4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    o1 = ($urandom_range(4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    if (ph == 0) begin
      st = 0; bl = 1; nf = 2; o0 = 8; o1 = 8;
    end
    if (ph == 4) begin
      // long frame over the widest bands: bin count pins at its top
      apply_config(6'd63, 9'd511, 2'd2, 4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                   rand_coeffs(), rand_coeffs());
      for (int i = 0; i < 530; i++) push_request(rand_sample(), i == 0);
    end else begin
      apply_config(st, bl, nf, o0, o1, rand_coeffs(), rand_coeffs());
      run_frames(8, 2 * bl + st + 4);
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    in_frame_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    requests_sent = 0;
    settings_used = 0;
    set_idling(0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every bin passes through
    push_request({1'b0, {(SW-1){1'b1}}}, 1'b1);
    push_request({1'b1, {(SW-1){1'b0}}}, 1'b0);
    push_request('1, 1'b0);
    drain();

    // full-magnitude coefficients on both bands, saturating samples, bin past both bands
    apply_config(6'd0, 9'd4, 2'd2, 4'd8, 4'd8, {8{5'd8}}, {8{5'b11000}});
    push_request({1'b0, {(SW-1){1'b1}}}, 1'b1);
    push_request({1'b0, {(SW-1){1'b1}}}, 1'b0);
    push_request({1'b1, {(SW-1){1'b0}}}, 1'b0);
    push_request({1'b1, {(SW-1){1'b0}}}, 1'b0);
    push_request('0, 1'b0);
    push_request({1'b0, {(SW-1){1'b1}}}, 1'b0);
    push_request({1'b0, {(SW-1){1'b1}}}, 1'b0);
    push_request({1'b1, {(SW-1){1'b0}}}, 1'b0);
    push_request(SW'(1), 1'b0);
    drain();

    // indices beyond the table, order above the stage count, filter count of three
    apply_config(6'd2, 9'd5, 2'd3, 4'd15, 4'd3,
                 {5'd24, 5'd8, 5'd17, 5'd12, 5'd23, 5'd16, 5'd15, 5'd9}, rand_coeffs());
    for (int i = 0; i < 5; i++) push_request(rand_sample(), i == 0);
    // frame start mid-band clears the lattice
    push_request({1'b0, {(SW-1){1'b1}}}, 1'b1);
    push_request(rand_sample(), 1'b0);
    push_request(rand_sample(), 1'b0);
    drain();

    // zero band length with filter count zero: pass through
    apply_config(6'd0, 9'd0, 2'd0, 4'd8, 4'd8, rand_coeffs(), rand_coeffs());
    push_request(rand_sample(), 1'b1);
    push_request(rand_sample(), 1'b0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      set_idling(ph / 3);
      random_phase(ph);
    end

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d requests across %0d register settings; %0d results compared, %0d bad.",
             requests_sent, settings_used, predictor.compared, predictor.mismatches);
    $display("Traffic ran with sender-heavy, receiver-heavy and no idling.");
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: tns_inverse_lattice_filter_unit.f
hdl/tnsilf_pkg.sv
hdl/tnsilf_seq.sv
hdl/tns_inverse_lattice_filter_unit.sv
tb/sv/testbench.sv
